### hw/rtl/lhit_pkg.sv
// Package for the linear-hashing insert table: status codes, sequencer
// states and fixed field widths. No dependencies.
package lhit_pkg;

	localparam int KEY_W    = 32;
	localparam int CAP_W    = 5;
	localparam int STATUS_W = 2;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd4;

	typedef enum logic [STATUS_W-1:0] {
		ST_STORED = 2'd0,
		ST_DUP    = 2'd1,
		ST_FULL   = 2'd2,
		ST_SKIP   = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_HOME,
		S_FILL,
		S_SCAN,
		S_SPL_RD,
		S_SPL_N,
		S_WALK,
		S_SPL_WR,
		S_SPL_WR2,
		S_DONE
	} state_t;

endpackage

### hw/rtl/lhit_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lhit_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port, old data on a same-cycle write
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/lhit_home.sv
// Home bucket unit: masks a key by the current hash level and split pointer.
// Shared between the lookup and the split walk. No package dependencies.
module lhit_home #(
	parameter int BW = 6,
	parameter int LW = 3,
	parameter int CW = 7,
	parameter int MAX_BUCKETS = 64
) (
	input  logic [BW:0]   key_lo,
	input  logic [LW-1:0] level,
	input  logic [CW-1:0] split_ptr,
	output logic [BW-1:0] bucket
);

	localparam int HW = BW + 1;

	logic [HW-1:0] mask_lo;
	logic [HW-1:0] mask_hi;
	logic [HW-1:0] lo;
	logic [HW-1:0] b;

	// narrow mask first, widen by one bit below the split pointer
	always_comb begin
		mask_lo = (HW'(1) << level) - HW'(1);
		mask_hi = (HW'(2) << level) - HW'(1);
		lo      = key_lo & mask_lo;
		b       = (lo < HW'(split_ptr)) ? (key_lo & mask_hi) : lo;
		if (b >= HW'(MAX_BUCKETS)) begin
			bucket = BW'(MAX_BUCKETS - 1);
		end else begin
			bucket = BW'(b);
		end
	end

endmodule

### hw/rtl/linear_hash_insert_table_top.sv
// Linear-hashing insert table, top level: sequencer, state registers and
// memories. Depends on lhit_pkg, lhit_ram and lhit_home.
//
// Usage:
//   Input channel (in_valid/in_ready/key) carries one key word per insert.
//   Output channel (out_valid/out_ready/echo_key/status) returns exactly one
//   word per key: 0 stored, 1 duplicate, 2 bucket full, 3 stored, split skipped.
//   cfg_we/cfg_wdata write bucket_capacity; write only while the block is idle.
// Sequencing:
//   One key at a time. A key is looked up by scanning the keys in its home
//   bucket (up to SLOTS_PER_BUCKET), and a split, when one follows, walks
//   the keys of the split bucket; the result may then wait on the output register.
//   Both the duplicate scan and the split walk go through the single read
//   port of the key store, one key per cycle.
// Reset:
//   Every bucket is empty, hash level 0, split pointer 0, one bucket,
//   capacity 4. No clearing pass: fills beyond the bucket count are never
//   read, and bucket 0 reads empty until its first write.
// Stall:
//   The result sits in an output register; the next key is accepted while it
//   waits, but its result is held back until the register is free.
module linear_hash_insert_table_top
	import lhit_pkg::*;
#(
	parameter int MAX_BUCKETS      = 64,
	parameter int SLOTS_PER_BUCKET = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [KEY_W-1:0]  key,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [KEY_W-1:0]  echo_key,
	output logic [STATUS_W-1:0]      status,
	input  logic                     cfg_we,
	input  logic [CAP_W-1:0]         cfg_wdata
);

	localparam int BW    = $clog2(MAX_BUCKETS);
	localparam int CW    = $clog2(MAX_BUCKETS + 1);
	localparam int LW    = $clog2(BW + 1);
	localparam int FW    = $clog2(SLOTS_PER_BUCKET + 1);
	localparam int SW    = $clog2(SLOTS_PER_BUCKET);
	localparam int DEPTH = MAX_BUCKETS * SLOTS_PER_BUCKET;
	localparam int AW    = $clog2(DEPTH);
	localparam int CMPW  = ((FW > CAP_W) ? FW : CAP_W) + 1;

	state_t state_q, state_d;

	// control registers
	logic [LW-1:0]    lvl_q;
	logic [CW-1:0]    sp_q;
	logic [CW-1:0]    cnt_q;
	logic [CAP_W-1:0] cap_q;
	logic             b0_q;
	logic             pend_q;
	logic             out_valid_q;

	// datapath registers
	logic [KEY_W-1:0] key_q;
	logic [BW-1:0]    bkt_q;
	logic [BW-1:0]    src_q;
	logic [BW-1:0]    dst_q;
	logic [FW-1:0]    n_q;
	logic [FW-1:0]    idx_q;
	logic [FW-1:0]    keep_q;
	logic [FW-1:0]    moved_q;
	status_t          stat_q;
	logic [KEY_W-1:0] echo_q;
	status_t          status_q;

	// memory ports
	logic             kram_we;
	logic [AW-1:0]    kram_waddr;
	logic [KEY_W-1:0] kram_wdata;
	logic [AW-1:0]    kram_raddr;
	logic [KEY_W-1:0] kram_rdata;
	logic             fram_we;
	logic [BW-1:0]    fram_waddr;
	logic [FW-1:0]    fram_wdata;
	logic [BW-1:0]    fram_raddr;
	logic [FW-1:0]    fram_rdata;

	// decisions
	logic [BW:0]   home_key_lo;
	logic [BW-1:0] home_b;
	logic          hit;
	logic          more;
	logic          full;
	logic          ovf;
	logic          at_max;
	logic          wrap;
	logic          ins;
	logic          split_go;
	logic          walk_home;
	logic          walk_end;
	logic          load_out;
	logic [BW-1:0] fill_sel;
	logic [FW-1:0] fill_rd;
	logic [CW-1:0] sp_base;

	function automatic logic [AW-1:0] slot_addr(input logic [BW-1:0] b,
		input logic [SW-1:0] s);
		slot_addr = AW'(AW'(b) * AW'(SLOTS_PER_BUCKET) + AW'(s));
	endfunction

	lhit_ram #(.WIDTH(KEY_W), .DEPTH(DEPTH)) u_key_ram (
		.clk   (clk),
		.we    (kram_we),
		.waddr (kram_waddr),
		.wdata (kram_wdata),
		.raddr (kram_raddr),
		.rdata (kram_rdata)
	);

	lhit_ram #(.WIDTH(FW), .DEPTH(MAX_BUCKETS)) u_fill_ram (
		.clk   (clk),
		.we    (fram_we),
		.waddr (fram_waddr),
		.wdata (fram_wdata),
		.raddr (fram_raddr),
		.rdata (fram_rdata)
	);

	// shared hash unit: the input key on lookup, the stored key on the walk
	assign home_key_lo = (state_q == S_WALK) ? kram_rdata[BW:0] : key_q[BW:0];

	lhit_home #(.BW(BW), .LW(LW), .CW(CW), .MAX_BUCKETS(MAX_BUCKETS)) u_home (
		.key_lo    (home_key_lo),
		.level     (lvl_q),
		.split_ptr (sp_q),
		.bucket    (home_b)
	);

	// compare and status terms
	always_comb begin
		hit       = pend_q && (kram_rdata == key_q);
		more      = idx_q < n_q;
		full      = n_q == FW'(SLOTS_PER_BUCKET);
		ovf       = (CMPW'(n_q) + CMPW'(1)) > CMPW'(cap_q);
		at_max    = cnt_q >= CW'(MAX_BUCKETS);
		wrap      = sp_q == (CW'(1) << lvl_q);
		sp_base   = wrap ? '0 : sp_q;
		ins       = (state_q == S_SCAN) && !hit && !more && !full;
		split_go  = ins && ovf && !at_max;
		walk_home = home_b == src_q;
		walk_end  = !pend_q && !more;
		load_out  = (state_q == S_DONE) && (!out_valid_q || out_ready);
		fill_sel  = (state_q == S_SPL_N) ? src_q : bkt_q;
		fill_rd   = ((fill_sel == '0) && !b0_q) ? '0 : fram_rdata;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:    if (in_valid) state_d = S_HOME;
			S_HOME:    state_d = S_FILL;
			S_FILL:    state_d = S_SCAN;
			S_SCAN: begin
				if (hit) begin
					state_d = S_DONE;
				end else if (more) begin
					state_d = S_SCAN;
				end else if (split_go) begin
					state_d = S_SPL_RD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SPL_RD:  state_d = S_SPL_N;
			S_SPL_N:   state_d = S_WALK;
			S_WALK:    if (walk_end) state_d = S_SPL_WR;
			S_SPL_WR:  state_d = S_SPL_WR2;
			S_SPL_WR2: state_d = S_DONE;
			S_DONE:    if (load_out) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	// memory control per state
	always_comb begin
		in_ready   = 1'b0;
		kram_we    = 1'b0;
		kram_waddr = slot_addr(bkt_q, n_q[SW-1:0]);
		kram_wdata = key_q;
		kram_raddr = slot_addr(bkt_q, idx_q[SW-1:0]);
		fram_we    = 1'b0;
		fram_waddr = bkt_q;
		fram_wdata = n_q + FW'(1);
		fram_raddr = home_b;
		unique case (state_q)
			S_IDLE:   in_ready = 1'b1;
			S_SCAN: begin
				if (ins) begin
					kram_we = 1'b1;
					fram_we = 1'b1;
				end
			end
			S_SPL_RD: fram_raddr = src_q;
			S_WALK: begin
				kram_raddr = slot_addr(src_q, idx_q[SW-1:0]);
				kram_wdata = kram_rdata;
				kram_we    = pend_q;
				kram_waddr = walk_home ? slot_addr(src_q, keep_q[SW-1:0])
					: slot_addr(dst_q, moved_q[SW-1:0]);
			end
			S_SPL_WR: begin
				fram_we    = 1'b1;
				fram_waddr = src_q;
				fram_wdata = keep_q;
			end
			S_SPL_WR2: begin
				fram_we    = 1'b1;
				fram_waddr = dst_q;
				fram_wdata = moved_q;
			end
			S_HOME, S_FILL, S_SPL_N, S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// control state: sequencer, hash level, split pointer, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			lvl_q       <= '0;
			sp_q        <= '0;
			cnt_q       <= CW'(1);
			cap_q       <= CAP_RESET;
			b0_q        <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (fram_we && (fram_waddr == '0)) begin
				b0_q <= 1'b1;
			end
			// advance level on wrap, then step pointer and count for the split
			if (split_go) begin
				if (wrap) begin
					lvl_q <= lvl_q + LW'(1);
				end
				sp_q  <= sp_base + CW'(1);
				cnt_q <= cnt_q + CW'(1);
			end
			pend_q <= ((state_q == S_SCAN) && !hit && more)
				|| ((state_q == S_WALK) && more);
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath: key, bucket, counters, result word
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && in_valid) begin
			key_q <= key;
		end
		if (state_q == S_HOME) begin
			bkt_q <= home_b;
		end
		if (state_q == S_FILL) begin
			n_q   <= fill_rd;
			idx_q <= '0;
		end
		if (state_q == S_SCAN) begin
			if (!hit && more) begin
				idx_q <= idx_q + FW'(1);
			end
			if (hit) begin
				stat_q <= ST_DUP;
			end else if (!more) begin
				if (full) begin
					stat_q <= ST_FULL;
				end else if (ovf && at_max) begin
					stat_q <= ST_SKIP;
				end else begin
					stat_q <= ST_STORED;
				end
			end
		end
		if (split_go) begin
			src_q <= BW'(sp_base);
			dst_q <= BW'(cnt_q);
		end
		if (state_q == S_SPL_N) begin
			n_q     <= fill_rd;
			idx_q   <= '0;
			keep_q  <= '0;
			moved_q <= '0;
		end
		// walk: read next key, drop the previous one into its bucket
		if (state_q == S_WALK) begin
			if (more) begin
				idx_q <= idx_q + FW'(1);
			end
			if (pend_q) begin
				if (walk_home) begin
					keep_q <= keep_q + FW'(1);
				end else begin
					moved_q <= moved_q + FW'(1);
				end
			end
		end
		if (load_out) begin
			echo_q   <= key_q;
			status_q <= stat_q;
		end
	end

	assign out_valid = out_valid_q;
	assign echo_key  = echo_q;
	assign status    = status_q;

`ifndef ASSERT_OFF
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (cnt_q == ((CW'(1) << lvl_q) + sp_q)))
		else $error("bucket count out of step with level and split pointer");

	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(sp_q <= (CW'(1) << lvl_q)) && (cnt_q <= CW'(MAX_BUCKETS)))
		else $error("split pointer or bucket count out of range");

	a_walk_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> ((FW+1)'(keep_q) + (FW+1)'(moved_q) <= (FW+1)'(idx_q)))
		else $error("split walk placed more keys than it read");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_HOME))
		else $error("accepted word did not start a lookup");
`endif

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for linear_hash_insert_table_top: streams keys, predicts each
// insert outcome with its own copy of the linear-hashing set and checks every word.
// Depends on lhit_pkg and the block's RTL.
module testbench
	import lhit_pkg::*;
();

	localparam int TABLE_BUCKETS = 64;
	localparam int BUCKET_SLOTS  = 16;
	localparam int CHUNK_KEYS    = 330;
	localparam int HOLD_AFTER    = 200;
	localparam int HOLD_CYCLES   = 400;
	localparam int DRAIN_CYCLES  = 60;

	typedef struct {
		logic [KEY_W-1:0] key;
		status_t          status;
	} insert_outcome_t;

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    in_valid  = 1'b0;
	logic                    in_ready;
	logic signed [KEY_W-1:0] key       = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic signed [KEY_W-1:0] echo_key;
	logic [STATUS_W-1:0]     status;
	logic                    cfg_we    = 1'b0;
	logic [CAP_W-1:0]        cfg_wdata = '0;

	// Predicted set contents
	logic [KEY_W-1:0] set_keys [TABLE_BUCKETS*BUCKET_SLOTS];
	int unsigned      set_fill [TABLE_BUCKETS];
	int unsigned      set_level;
	int unsigned      set_split;
	int unsigned      set_buckets;
	int unsigned      set_capacity;

	logic [KEY_W-1:0] key_backlog[$];
	logic [KEY_W-1:0] keys_sent[$];
	insert_outcome_t  awaited_outcomes[$];

	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	int   error_count   = 0;
	int   results_seen  = 0;
	int   hold_left     = 0;
	bit   hold_done     = 1'b0;
	logic [5:0] hot_low = '0;

	linear_hash_insert_table_top #(
		.MAX_BUCKETS      (TABLE_BUCKETS),
		.SLOTS_PER_BUCKET (BUCKET_SLOTS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.key       (key),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.echo_key  (echo_key),
		.status    (status),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Home bucket under the current level and split pointer
	function automatic int unsigned home_bucket(logic [KEY_W-1:0] k);
		logic [KEY_W-1:0] mask;
		mask = (32'd1 << set_level) - 32'd1;
		if ((k & mask) < set_split)
			mask = (32'd2 << set_level) - 32'd1;
		return k & mask;
	endfunction

	// Insert one key into the predicted set and return its status
	function automatic status_t insert_key(logic [KEY_W-1:0] k);
		int unsigned b, n, src, dst, keep, moved;
		logic [KEY_W-1:0] held;
		b = home_bucket(k);
		n = set_fill[b];
		for (int i = 0; i < n; i++)
			if (set_keys[b*BUCKET_SLOTS + i] == k)
				return ST_DUP;
		if (n >= BUCKET_SLOTS)
			return ST_FULL;
		set_keys[b*BUCKET_SLOTS + n] = k;
		n++;
		set_fill[b] = n;
		if (n > set_capacity) begin
			if (set_buckets >= TABLE_BUCKETS)
				return ST_SKIP;
			if (set_split == (32'd1 << set_level)) begin
				set_level++;
				set_split = 0;
			end
			// split the bucket under the pointer, keeping order on both sides
			src = set_split;
			dst = set_buckets;
			set_split++;
			set_buckets++;
			keep = 0;
			moved = 0;
			for (int i = 0; i < set_fill[src]; i++) begin
				held = set_keys[src*BUCKET_SLOTS + i];
				if (home_bucket(held) != src) begin
					set_keys[dst*BUCKET_SLOTS + moved] = held;
					moved++;
				end else begin
					set_keys[src*BUCKET_SLOTS + keep] = held;
					keep++;
				end
			end
			set_fill[src] = keep;
			set_fill[dst] = moved;
		end
		return ST_STORED;
	endfunction

	task automatic report_mismatch(string what, logic [KEY_W-1:0] got, logic [KEY_W-1:0] want);
		$display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
		error_count++;
	endtask

	task automatic send_key(logic [KEY_W-1:0] k);
		key_backlog = {key_backlog, k};
		keys_sent = {keys_sent, k};
	endtask

	// Hold until every queued word is accepted and every result has come back
	task automatic wait_drained();
		do
			@(posedge clk);
		while (key_backlog.size() != 0 || in_valid || awaited_outcomes.size() != 0
			|| results_seen < keys_sent.size());
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		set_capacity = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Driver: predict on acceptance, then offer the next key or idle
	always @(posedge clk) begin : driver_proc
		insert_outcome_t outcome;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				outcome.key = key;
				outcome.status = insert_key(key);
				awaited_outcomes = {awaited_outcomes, outcome};
			end
			if (!in_valid || in_ready) begin
				if (key_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					key <= key_backlog.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each result word against the oldest prediction, drive ready
	always @(posedge clk) begin : monitor_proc
		insert_outcome_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (awaited_outcomes.size() == 0) begin
					report_mismatch("unawaited word, echo_key", echo_key, '0);
				end else begin
					want = awaited_outcomes.pop_front();
					if (echo_key !== want.key)
						report_mismatch("echo_key", echo_key, want.key);
					if (status !== want.status)
						report_mismatch("status", KEY_W'(status), KEY_W'(want.status));
				end
			end
			// one long hold-off so the block backs up into its input
			if (!hold_done && results_seen >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin : stimulus
		logic [KEY_W-1:0] edge_keys [10];
		logic [CAP_W-1:0] chunk_caps [6];
		logic [KEY_W-1:0] k;
		int unsigned      pick;
		edge_keys = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000, 32'h5555_5555,
			32'hAAAA_AAAA, 32'h8000_0000};
		chunk_caps = '{5'd1, 5'd16, 5'd0, 5'd2, 5'd31, 5'($urandom_range(15, 3))};
		foreach (set_fill[b])
			set_fill[b] = 0;
		set_level = 0;
		set_split = 0;
		set_buckets = 1;
		set_capacity = CAP_RESET;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// extremes and repeats at the reset capacity
		foreach (edge_keys[i])
			send_key(edge_keys[i]);
		// capacity zero: every fresh insert splits
		wait_drained();
		write_capacity(5'd0);
		for (int i = 2; i < 8; i++)
			send_key(KEY_W'(i));
		// capacity above the slot count: never overflow
		wait_drained();
		write_capacity(5'd31);
		send_key(32'h0000_0010);
		send_key(32'h0000_0020);
		send_key(32'h0000_0030);
		send_key(32'h0000_0010);

		// random chunks: fresh keys, repeats and keys piled onto one bucket
		for (int chunk = 0; chunk < 6; chunk++) begin
			wait_drained();
			write_capacity(chunk_caps[chunk]);
			send_idle_pct = (chunk < 2) ? 30 : (chunk < 4) ? 82 : 0;
			recv_idle_pct = (chunk < 2) ? 82 : (chunk < 4) ? 30 : 0;
			repeat (CHUNK_KEYS) begin
				if ($urandom_range(39) == 0)
					hot_low = 6'($urandom_range(63));
				pick = $urandom_range(99);
				if (pick < 25) begin
					k = keys_sent[$urandom_range(keys_sent.size() - 1)];
				end else begin
					k = $urandom();
					if (pick < 45)
						k[5:0] = hot_low;
				end
				send_key(k);
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// Guard against a hung handshake
	initial begin : watchdog
		#20_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

### filelist.f
hw/rtl/lhit_pkg.sv
hw/rtl/lhit_ram.sv
hw/rtl/lhit_home.sv
hw/rtl/linear_hash_insert_table_top.sv
sim/testbench.sv
